@@ src/ohlc_pkg.sv @@
// ohlc_pkg: shared types and constants for the ohlc bar aggregator
// no dependencies
package ohlc_pkg;

  localparam int unsigned TS_W    = 48;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned VOL_W   = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned IV_W    = 27;
  localparam int unsigned SYM_W   = 4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_UPDATE,
    ST_FLUSH_RD,
    ST_FLUSH_EMIT
  } state_t;

  typedef struct packed {
    logic [TS_W-1:0]    bucket_ts;
    logic [TS_W-1:0]    last_ts;
    logic [PRICE_W-1:0] open;
    logic [PRICE_W-1:0] high;
    logic [PRICE_W-1:0] low;
    logic [PRICE_W-1:0] close;
    logic [VOL_W-1:0]   volume;
    logic [PRICE_W-1:0] bid;
    logic [PRICE_W-1:0] ask;
  } bar_t;

endpackage

@@ src/ohlc_div.sv @@
// ohlc_div: restoring divider, floors the timestamp to a multiple of the interval via the remainder, one bit a cycle
// depends on ohlc_pkg
module ohlc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ohlc_pkg::TS_W-1:0] dividend,
  input  logic [ohlc_pkg::IV_W-1:0] divisor,
  output logic                      done,
  output logic [ohlc_pkg::TS_W-1:0] floor_val
);
  import ohlc_pkg::*;

  logic [TS_W-1:0]        num;
  logic [TS_W-1:0]        orig;
  logic [IV_W-1:0]        dv;
  logic [IV_W:0]          rem;
  logic [$clog2(TS_W):0]  cnt;
  logic                   run;
  logic [IV_W:0]          shifted;
  logic                   ge;

  assign shifted = {rem[IV_W-1:0], num[TS_W-1]};
  assign ge      = shifted >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= '0;
        num  <= dividend;
        orig <= dividend;
        dv   <= (divisor == '0) ? IV_W'(1) : divisor;
        rem  <= '0;
      end else if (run) begin
        num <= {num[TS_W-2:0], 1'b0};
        rem <= ge ? (shifted - {1'b0, dv}) : shifted;
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(TS_W)+1)'(TS_W-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign floor_val = orig - TS_W'(rem);
endmodule

@@ src/ohlc_table.sv @@
// ohlc_table: bar store, one synchronous memory; the per-slot tick counts are kept in the top level
// depends on ohlc_pkg
module ohlc_table #(
  parameter int unsigned SYMBOLS = 16
) (
  input  logic                                              clk,
  input  logic [((SYMBOLS > 1) ? $clog2(SYMBOLS) : 1)-1:0] rd_addr,
  output ohlc_pkg::bar_t                                    rd_data,
  input  logic                                              wr_en,
  input  logic [((SYMBOLS > 1) ? $clog2(SYMBOLS) : 1)-1:0] wr_addr,
  input  ohlc_pkg::bar_t                                    wr_data
);
  import ohlc_pkg::*;

  bar_t mem [SYMBOLS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

@@ src/ohlc_bar_aggregator_top.sv @@
// ohlc_bar_aggregator_top: per-symbol ohlcv time bar table
// depends on ohlc_pkg, ohlc_div, ohlc_table
//
// usage: an item is taken when start is high and busy is low.
// operation tick with a trade buckets timestamp_ms down to a multiple of
// the bar length (0 acts as 1) and updates the symbol's bar; a bucket change
// first emits the old bar. flush emits every active bar in slot order with
// last on the final one, then clears. clear drops all bars silently.
// each result appears for one cycle with out_valid high; the receiver cannot
// stall, so nothing waits on it.
// a tick holds busy through the bit-serial remainder unit (48 steps and its done
// flag), then a table read and a read-modify-write; a rollover bar is on the
// outputs in the first idle cycle after. flush passes a read state and an emit
// state for each active slot, one bar per slot. clear and ignored items never
// raise busy.
// reset clears all bars (tick counts live in flip-flops) and sets
// the bar length to 60000. cfg_valid/cfg_ready writes the bar length while idle.
module ohlc_bar_aggregator_top #(
  parameter int unsigned SYMBOLS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation,
  input  logic [ohlc_pkg::SYM_W-1:0]   symbol_index,
  input  logic [ohlc_pkg::TS_W-1:0]    timestamp_ms,
  input  logic                         trade_flag,
  input  logic [ohlc_pkg::PRICE_W-1:0] price,
  input  logic [ohlc_pkg::PRICE_W-1:0] quantity,
  input  logic [ohlc_pkg::PRICE_W-1:0] bid_price,
  input  logic [ohlc_pkg::PRICE_W-1:0] ask_price,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ohlc_pkg::IV_W-1:0]    cfg_data,
  output logic                         out_valid,
  output logic [ohlc_pkg::SYM_W-1:0]   out_symbol,
  output logic [ohlc_pkg::TS_W-1:0]    bucket_ts,
  output logic [ohlc_pkg::TS_W-1:0]    last_ts,
  output logic [ohlc_pkg::PRICE_W-1:0] open,
  output logic [ohlc_pkg::PRICE_W-1:0] high,
  output logic [ohlc_pkg::PRICE_W-1:0] low,
  output logic [ohlc_pkg::PRICE_W-1:0] close,
  output logic [ohlc_pkg::VOL_W-1:0]   volume,
  output logic [ohlc_pkg::CNT_W-1:0]   trade_count,
  output logic [ohlc_pkg::PRICE_W-1:0] last_bid,
  output logic [ohlc_pkg::PRICE_W-1:0] last_ask,
  output logic                         last
);
  import ohlc_pkg::*;
  localparam int unsigned SYM_AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  state_t state, state_next;
  logic [IV_W-1:0]    bar_len_ms;
  logic [CNT_W-1:0]   ticks [SYMBOLS];
  logic [SYMBOLS-1:0] active;

  logic [SYM_AW-1:0]  slot;
  logic [TS_W-1:0]    ts;
  logic [PRICE_W-1:0] px, qty, bid, ask;
  logic [TS_W-1:0]    bstart;

  logic               accept;
  logic               div_done;
  logic [TS_W-1:0]    div_floor;
  bar_t               rd_data, wr_data;
  logic               wr_en;
  logic [SYM_AW-1:0]  next_slot;
  logic               in_range;
  logic               roll;
  logic               fresh;
  logic [VOL_W:0]     vsum;
  logic [SYMBOLS-1:0] later_mask;
  logic               more;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_range  = (32'(symbol_index) < SYMBOLS);

  ohlc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && operation == OP_TICK && trade_flag && in_range),
    .dividend  (timestamp_ms),
    .divisor   (bar_len_ms),
    .done      (div_done),
    .floor_val (div_floor)
  );

  ohlc_table #(.SYMBOLS(SYMBOLS)) u_table (
    .clk     (clk),
    .rd_addr (slot),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (wr_data)
  );

  always_comb begin
    for (int i = 0; i < SYMBOLS; i++) active[i] = (ticks[i] != '0);
  end

  always_comb begin
    for (int i = 0; i < SYMBOLS; i++) later_mask[i] = (SYM_AW'(i) > slot) && active[i];
  end
  assign more = |later_mask;

  always_comb begin
    next_slot = slot;
    for (int i = SYMBOLS-1; i >= 0; i--) begin
      if (later_mask[i]) next_slot = SYM_AW'(i);
    end
  end

  assign roll  = active[slot] && (rd_data.bucket_ts != bstart);
  assign fresh = !active[slot] || roll;
  assign vsum  = (fresh ? (VOL_W+1)'(0) : {1'b0, rd_data.volume}) + (VOL_W+1)'(qty);

  always_comb begin
    wr_data.bucket_ts = bstart;
    wr_data.last_ts   = ts;
    wr_data.open      = fresh ? px : rd_data.open;
    wr_data.high      = (fresh || px > rd_data.high) ? px : rd_data.high;
    wr_data.low       = (fresh || px < rd_data.low) ? px : rd_data.low;
    wr_data.close     = px;
    wr_data.volume    = vsum[VOL_W] ? {VOL_W{1'b1}} : vsum[VOL_W-1:0];
    wr_data.bid       = bid;
    wr_data.ask       = ask;
  end

  always_comb begin
    wr_en = (state == ST_UPDATE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_TICK && trade_flag && in_range) state_next = ST_DIV;
          else if (operation == OP_FLUSH && active != '0) state_next = ST_FLUSH_RD;
        end
      end
      ST_DIV:        if (div_done) state_next = ST_READ;
      ST_READ:       state_next = ST_UPDATE;
      ST_UPDATE:     state_next = ST_IDLE;
      ST_FLUSH_RD:   state_next = ST_FLUSH_EMIT;
      ST_FLUSH_EMIT: state_next = more ? ST_FLUSH_RD : ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bar_len_ms <= IV_W'(60000);
      out_valid  <= 1'b0;
      for (int i = 0; i < SYMBOLS; i++) ticks[i] <= '0;
    end else begin
      state     <= state_next;
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) bar_len_ms <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            ts   <= timestamp_ms;
            px   <= price;
            qty  <= quantity;
            bid  <= bid_price;
            ask  <= ask_price;
            if (operation == OP_CLEAR) for (int i = 0; i < SYMBOLS; i++) ticks[i] <= '0;
            if (operation == OP_FLUSH) begin
              for (int i = 0; i < SYMBOLS; i++) begin
                if (active[i] && !(|(active & ((SYMBOLS)'(1) << i) - 1'b1))) slot <= SYM_AW'(i);
              end
            end else begin
              slot <= SYM_AW'(symbol_index);
            end
          end
        end
        ST_DIV: bstart <= div_floor;
        ST_READ: ;
        ST_UPDATE: begin
          if (roll) begin
            out_valid   <= 1'b1;
            last        <= 1'b1;
            out_symbol  <= SYM_W'(slot);
            bucket_ts   <= rd_data.bucket_ts;
            last_ts     <= rd_data.last_ts;
            open        <= rd_data.open;
            high        <= rd_data.high;
            low         <= rd_data.low;
            close       <= rd_data.close;
            volume      <= rd_data.volume;
            trade_count <= ticks[slot];
            last_bid    <= rd_data.bid;
            last_ask    <= rd_data.ask;
          end
          if (fresh) ticks[slot] <= CNT_W'(1);
          else if (ticks[slot] != '1) ticks[slot] <= ticks[slot] + 1'b1;
        end
        ST_FLUSH_RD: ;
        ST_FLUSH_EMIT: begin
          out_valid   <= 1'b1;
          last        <= !more;
          out_symbol  <= SYM_W'(slot);
          bucket_ts   <= rd_data.bucket_ts;
          last_ts     <= rd_data.last_ts;
          open        <= rd_data.open;
          high        <= rd_data.high;
          low         <= rd_data.low;
          close       <= rd_data.close;
          volume      <= rd_data.volume;
          trade_count <= ticks[slot];
          last_bid    <= rd_data.bid;
          last_ask    <= rd_data.ask;
          if (more) slot <= next_slot;
          else for (int i = 0; i < SYMBOLS; i++) ticks[i] <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ test/ohlc_bar_aggregator_top_tb.sv @@
// ohlc_bar_aggregator_top_tb: self-checking bench for the ohlc bar aggregator
// drives ticks, flushes and clears through the start/busy port, predicts the emitted bars
// depends on ohlc_pkg and ohlc_bar_aggregator_top
`timescale 1ns / 100ps

module ohlc_bar_aggregator_top_tb;
  import ohlc_pkg::*;

  localparam int NSLOT = 16;
  localparam logic [47:0] TS_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] W_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic [3:0]  sym;
    logic [47:0] t_start;
    logic [47:0] t_end;
    logic [31:0] p_open;
    logic [31:0] p_high;
    logic [31:0] p_low;
    logic [31:0] p_close;
    logic [47:0] vol;
    logic [31:0] cnt;
    logic [31:0] bid;
    logic [31:0] ask;
    logic        fin;
  } bar_rec_t;

  typedef struct {
    op_t         op;
    logic [3:0]  sym;
    logic [47:0] ts;
    logic        trade;
    logic [31:0] px;
    logic [31:0] qty;
    logic [31:0] bid;
    logic [31:0] ask;
    bit          none_typed;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] operation = OP_NONE;
  logic [3:0] symbol_index = '0;
  logic [47:0] timestamp_ms = '0;
  logic trade_flag = 1'b0;
  logic [31:0] price = '0, quantity = '0, bid_price = '0, ask_price = '0;
  logic cfg_valid = 1'b0;
  logic [26:0] cfg_data = '0;
  logic busy, cfg_ready, out_valid, last;
  logic [3:0] out_symbol;
  logic [47:0] bucket_ts, last_ts, volume;
  logic [31:0] open, high, low, close, trade_count, last_bid, last_ask;

  ohlc_bar_aggregator_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .symbol_index(symbol_index), .timestamp_ms(timestamp_ms), .trade_flag(trade_flag),
    .price(price), .quantity(quantity), .bid_price(bid_price), .ask_price(ask_price),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_symbol(out_symbol), .bucket_ts(bucket_ts),
    .last_ts(last_ts), .open(open), .high(high), .low(low), .close(close),
    .volume(volume), .trade_count(trade_count), .last_bid(last_bid),
    .last_ask(last_ask), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the bar table
  logic [26:0] bar_len = 27'd60000;
  logic [31:0] m_open[NSLOT], m_high[NSLOT], m_low[NSLOT], m_close[NSLOT];
  logic [31:0] m_cnt[NSLOT], m_bid[NSLOT], m_ask[NSLOT];
  logic [47:0] m_vol[NSLOT], m_start[NSLOT], m_end[NSLOT];
  bar_rec_t pending_bars[$];
  int errors = 0, items = 0, bars_seen = 0, rollovers = 0, settings = 0;
  bit no_gaps = 0;
  longint unsigned tcur[NSLOT];

  function automatic bar_rec_t slot_bar(int s, logic fin);
    bar_rec_t b;
    b.sym = s[3:0];
    b.t_start = m_start[s]; b.t_end = m_end[s];
    b.p_open = m_open[s]; b.p_high = m_high[s]; b.p_low = m_low[s];
    b.p_close = m_close[s]; b.vol = m_vol[s]; b.cnt = m_cnt[s];
    b.bid = m_bid[s]; b.ask = m_ask[s]; b.fin = fin;
    return b;
  endfunction

  task automatic apply_item(tick_row_t r, bit push);
    logic [47:0] ivl, bucket;
    logic [48:0] vsum;
    int nflush;
    ivl = (bar_len == 0) ? 48'd1 : {21'd0, bar_len};
    if (r.op == OP_TICK && r.trade) begin
      bucket = r.ts - (r.ts % ivl);
      if (m_cnt[r.sym] != 0 && m_start[r.sym] != bucket) begin
        if (push) pending_bars.push_back(slot_bar(r.sym, 1'b1));
        rollovers++;
        m_cnt[r.sym] = '0;
      end
      if (m_cnt[r.sym] == 0) begin
        m_start[r.sym] = bucket;
        m_open[r.sym] = r.px; m_high[r.sym] = r.px; m_low[r.sym] = r.px;
        m_vol[r.sym] = '0;
      end else begin
        if (r.px > m_high[r.sym]) m_high[r.sym] = r.px;
        if (r.px < m_low[r.sym]) m_low[r.sym] = r.px;
      end
      m_close[r.sym] = r.px;
      vsum = {1'b0, m_vol[r.sym]} + {17'd0, r.qty};
      m_vol[r.sym] = vsum[48] ? TS_MAX : vsum[47:0];
      if (m_cnt[r.sym] != W_MAX) m_cnt[r.sym]++;
      m_end[r.sym] = r.ts;
      m_bid[r.sym] = r.bid; m_ask[r.sym] = r.ask;
    end else if (r.op == OP_FLUSH) begin
      nflush = 0;
      for (int s = 0; s < NSLOT; s++) if (m_cnt[s] != 0) nflush++;
      for (int s = 0; s < NSLOT; s++) begin
        if (m_cnt[s] != 0) begin
          nflush--;
          if (push) pending_bars.push_back(slot_bar(s, nflush == 0));
        end
      end
      for (int s = 0; s < NSLOT; s++) m_cnt[s] = '0;
    end else if (r.op == OP_CLEAR) begin
      for (int s = 0; s < NSLOT; s++) m_cnt[s] = '0;
    end
  endtask

  // one transfer on the command port; start stays high for a following item
  task automatic issue(tick_row_t r);
    if (!no_gaps && $urandom_range(99) < 31) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    operation <= r.op; symbol_index <= r.sym; timestamp_ms <= r.ts;
    trade_flag <= r.trade; price <= r.px; quantity <= r.qty;
    bid_price <= r.bid; ask_price <= r.ask;
    @(posedge clk);
    while (busy) @(posedge clk);
    items++;
    // typed rows expect no bar at all, the model still tracks the table
    apply_item(r, !r.none_typed);
  endtask

  task automatic set_bar_len(logic [26:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending_bars.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    bar_len = v;
    settings++;
  endtask

  function automatic tick_row_t rand_row();
    tick_row_t r;
    int k;
    longint unsigned ivl;
    ivl = (bar_len == 0) ? 64'd1 : 64'(bar_len);
    k = $urandom_range(99);
    r.op = (k < 88) ? OP_TICK : (k < 93) ? OP_FLUSH : (k < 96) ? OP_CLEAR : OP_NONE;
    r.sym = ($urandom_range(99) < 70) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    r.trade = ($urandom_range(99) < 94);
    k = $urandom_range(99);
    if (k < 65) tcur[r.sym] += $urandom_range(0, 32'(ivl / 2));
    else if (k < 83) tcur[r.sym] += ivl * $urandom_range(1, 3);
    else if (k < 95) tcur[r.sym] -= (tcur[r.sym] > ivl) ? ivl : tcur[r.sym];
    else tcur[r.sym] = {$urandom, $urandom};
    tcur[r.sym] &= TS_MAX;
    r.ts = tcur[r.sym][47:0];
    r.px = ($urandom_range(99) < 60) ? 32'd1_000_000 + $urandom_range(0, 5000) : $urandom;
    r.qty = $urandom;
    r.bid = $urandom;
    r.ask = $urandom;
    r.none_typed = 1'b0;
    return r;
  endfunction

  task automatic check_field(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s expected %0h actual %0h", nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    bar_rec_t b;
    if (!rst && out_valid) begin
      bars_seen++;
      if (pending_bars.size() == 0) begin
        $error("bar from slot %0d with none expected", out_symbol);
        errors++;
      end else begin
        b = pending_bars.pop_front();
        check_field("out_symbol", 64'(b.sym), 64'(out_symbol));
        check_field("bucket_ts", 64'(b.t_start), 64'(bucket_ts));
        check_field("last_ts", 64'(b.t_end), 64'(last_ts));
        check_field("open", 64'(b.p_open), 64'(open));
        check_field("high", 64'(b.p_high), 64'(high));
        check_field("low", 64'(b.p_low), 64'(low));
        check_field("close", 64'(b.p_close), 64'(close));
        check_field("volume", 64'(b.vol), 64'(volume));
        check_field("trade_count", 64'(b.cnt), 64'(trade_count));
        check_field("last_bid", 64'(b.bid), 64'(last_bid));
        check_field("last_ask", 64'(b.ask), 64'(last_ask));
        check_field("last", 64'(b.fin), 64'(last));
      end
    end
  end

  tick_row_t directed[] = '{
    '{OP_FLUSH, 4'd0, 48'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1},
    '{OP_TICK, 4'd0, 48'd10, 1'b0, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1},
    '{OP_NONE, 4'd5, TS_MAX, 1'b1, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1},
    '{OP_TICK, 4'd0, 48'd0, 1'b1, 32'd0, W_MAX, 32'd0, W_MAX, 1'b0},
    '{OP_TICK, 4'd0, 48'd59999, 1'b1, W_MAX, W_MAX, W_MAX, 32'd0, 1'b0},
    '{OP_TICK, 4'd0, 48'd60000, 1'b1, 32'd5, 32'd7, 32'd4, 32'd6, 1'b0},
    '{OP_TICK, 4'd0, 48'd59999, 1'b1, 32'd3, 32'd1, 32'd2, 32'd4, 1'b0},
    '{OP_TICK, 4'd15, TS_MAX, 1'b1, 32'd1234, 32'd10, 32'd1230, 32'd1240, 1'b0},
    '{OP_TICK, 4'd7, 48'd120000, 1'b1, 32'd500, 32'd2, 32'd499, 32'd501, 1'b0},
    '{OP_TICK, 4'd7, 48'd179999, 1'b1, 32'd400, 32'd2, 32'd399, 32'd401, 1'b0},
    '{OP_TICK, 4'd7, 48'd150000, 1'b1, 32'd600, 32'd2, 32'd599, 32'd601, 1'b0},
    '{OP_FLUSH, 4'd0, 48'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0},
    '{OP_FLUSH, 4'd9, 48'd0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1},
    '{OP_TICK, 4'd3, 48'd1, 1'b1, 32'd77, 32'd1, 32'd76, 32'd78, 1'b0},
    '{OP_CLEAR, 4'd0, 48'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1},
    '{OP_FLUSH, 4'd0, 48'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1},
    '{OP_TICK, 4'd3, 48'd5, 1'b1, 32'd9, 32'd3, 32'd8, 32'd10, 1'b0},
    '{OP_TICK, 4'd3, 48'd6, 1'b1, 32'd9, 32'd3, 32'd8, 32'd10, 1'b0},
    '{OP_TICK, 4'd3, 48'd70000, 1'b1, 32'd11, 32'd3, 32'd10, 32'd12, 1'b0},
    '{OP_FLUSH, 4'd0, 48'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0}
  };

  logic [26:0] bar_lens[] = '{27'd1000, 27'd1, 27'd0, 27'd86400000, 27'h7FF_FFFF, 27'd250};

  initial begin
    tick_row_t r;
    for (int s = 0; s < NSLOT; s++) begin
      m_cnt[s] = '0;
      tcur[s] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) issue(directed[i]);
    foreach (bar_lens[p]) begin
      set_bar_len(bar_lens[p]);
      no_gaps = (p == 3);
      repeat (75) issue(rand_row());
      r = directed[0];
      r.none_typed = 1'b0;
      issue(r);
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending_bars.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d items over %0d interval settings, %0d bars checked, %0d rollovers",
             items, settings, bars_seen, rollovers);
    if (errors == 0 && pending_bars.size() == 0)
      $display("ohlc_bar_aggregator_top: match");
    else
      $display("ohlc_bar_aggregator_top: mismatch");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("ohlc_bar_aggregator_top: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
src/ohlc_pkg.sv
src/ohlc_div.sv
src/ohlc_table.sv
src/ohlc_bar_aggregator_top.sv
test/ohlc_bar_aggregator_top_tb.sv
